// File: design/lbc_pkg.sv
// Package for the block cache directory: result record, command and status
// structs, controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbc_pkg;

  localparam int unsigned FUNC_BITS    = 2;
  localparam int unsigned ID_BITS      = 16;
  localparam int unsigned SLOT_BITS    = 5;
  localparam int unsigned MAX_OUT      = 32;
  localparam int unsigned CNT_BITS     = 6;
  localparam int unsigned IN_BYTES_W   = 16;
  localparam int unsigned OUT_BYTES_W  = 32;

  localparam logic [FUNC_BITS-1:0] FUNC_READ   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FLUSH  = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_ACCESS,
    CMD_STEP
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
    logic flush_end;
  } stat_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 fill;
    logic                 writeback;
    logic [ID_BITS-1:0]   wb_block;
    logic [SLOT_BITS-1:0] wb_slot;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

// File: design/lru_block_cache_directory.sv
// Directory of a fully associative write-back block cache with LRU
// replacement. An access item is captured, then looked up and updated
// (parallel tag compare and rank update) once the output register is
// free, and gives one result with tlast set. A flush walks the recency
// ranks one per cycle while the output register is not stalled, most
// recent first, and gives one write-back item per dirty entry (at most 32),
// or one empty item when nothing is dirty. Items are taken one at a time.
// Depends on lbc_pkg, lbc_ctrl and lbc_datapath.
`timescale 1ns / 1ps
`default_nettype none
module lru_block_cache_directory
  import lbc_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // func [1:0]
  input  wire logic [FUNC_BITS-1:0]   s_tuser,
  // block number [15:0]
  input  wire logic [IN_BYTES_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // hit [0], slot [5:1], fill [6], writeback [7], wb_block [23:8],
  // wb_slot [28:24], zero [31:29]
  output logic [OUT_BYTES_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;

  lbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_func_i  (s_tuser),
    .in_ready_o (s_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lbc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_func_i   (s_tuser),
    .in_id_i     (s_tdata[ID_BITS-1:0]),
    .out_o       (res),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready)
  );

  assign m_tdata = {3'b000, res.wb_slot, res.wb_block, res.writeback, res.fill,
                    res.slot, res.hit};
  assign m_tlast = res.last;

endmodule
`default_nettype wire

// File: design/lbc_ctrl.sv
// Controller of the block cache directory: sequences capture, access and
// flush walk. Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbc_ctrl
  import lbc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [FUNC_BITS-1:0] in_func_i,
  output logic                      in_ready_o,
  input  wire stat_t                stat_i,
  output ctrl_t                     ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == FUNC_READ || in_func_i == FUNC_WRITE) begin
            state_d = ST_ACCESS;
          end else if (in_func_i == FUNC_FLUSH) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_ACCESS: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (!stat_i.out_busy && stat_i.flush_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    ctrl_o.cmd  = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.cmd = CMD_CAPTURE;
      end
      ST_ACCESS: begin
        if (!stat_i.out_busy) ctrl_o.cmd = CMD_ACCESS;
      end
      ST_FLUSH: begin
        if (!stat_i.out_busy) ctrl_o.cmd = CMD_STEP;
      end
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/lbc_datapath.sv
// Datapath of the block cache directory: tags, marks, recency ranks,
// flush walk and the output register. Depends on lbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbc_datapath
  import lbc_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctrl_t                ctrl_i,
  output stat_t                     stat_o,
  input  wire logic [FUNC_BITS-1:0] in_func_i,
  input  wire logic [ID_BITS-1:0]   in_id_i,
  output res_t                      out_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam logic [OW-1:0] FULL = OW'(ENTRIES);
  localparam logic [IW-1:0] LAST_RANK = IW'(ENTRIES - 1);

  logic [ID_BITS-1:0] tags_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q, dirty_q;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [OW-1:0]      occ_q, occ_d;
  logic               write_q;
  logic [ID_BITS-1:0] id_q;
  logic [OW-1:0]      walk_q;
  logic [CNT_BITS-1:0] cnt_q;
  res_t               pend_q, out_q;
  logic               pend_valid_q, out_valid_q;

  logic [ENTRIES-1:0] match, victim, sel;
  logic               hit, full, wb, sel_dirty, flush_end;
  logic [IW-1:0]      hit_idx, old_rank, vic_idx, new_idx, sel_idx;
  logic [ID_BITS-1:0] vic_tag, sel_tag;
  res_t               acc_res, sel_res, end_res;
  logic               do_acc, do_step, step_found;

  assign full = (occ_q == FULL);
  assign do_acc  = (ctrl_i.cmd == CMD_ACCESS);
  assign do_step = (ctrl_i.cmd == CMD_STEP);
  assign flush_end = (walk_q >= occ_q) || (cnt_q >= CNT_BITS'(MAX_OUT));

  always_comb begin
    hit_idx  = '0;
    old_rank = '0;
    vic_idx  = '0;
    vic_tag  = '0;
    sel_idx  = '0;
    sel_tag  = '0;
    wb       = 1'b0;
    sel_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (tags_q[i] == id_q);
      victim[i] = valid_q[i] && (rank_q[i] == LAST_RANK);
      sel[i]    = valid_q[i] && (rank_q[i] == walk_q[IW-1:0]);
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        old_rank = old_rank | rank_q[i];
      end
      if (victim[i]) begin
        vic_idx = vic_idx | IW'(i);
        vic_tag = vic_tag | tags_q[i];
        wb      = wb | dirty_q[i];
      end
      if (sel[i]) begin
        sel_idx   = sel_idx | IW'(i);
        sel_tag   = sel_tag | tags_q[i];
        sel_dirty = sel_dirty | dirty_q[i];
      end
    end
    hit = |match;
    new_idx = full ? vic_idx : occ_q[IW-1:0];
  end

  always_comb begin
    acc_res.hit       = hit;
    acc_res.slot      = hit ? SLOT_BITS'(hit_idx) : SLOT_BITS'(new_idx);
    acc_res.fill      = !hit;
    acc_res.writeback = !hit && full && wb;
    acc_res.wb_block  = acc_res.writeback ? vic_tag : '0;
    acc_res.wb_slot   = acc_res.writeback ? SLOT_BITS'(vic_idx) : '0;
    acc_res.last      = 1'b1;
    sel_res.hit       = 1'b0;
    sel_res.slot      = '0;
    sel_res.fill      = 1'b0;
    sel_res.writeback = 1'b1;
    sel_res.wb_block  = sel_tag;
    sel_res.wb_slot   = SLOT_BITS'(sel_idx);
    sel_res.last      = 1'b0;
    end_res           = pend_valid_q ? pend_q : '0;
    end_res.last      = 1'b1;
  end

  assign step_found = do_step && !flush_end && sel_dirty;

  always_ff @(posedge clk_i) begin
    if (do_acc && !hit) tags_q[new_idx] <= id_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_CAPTURE) begin
      write_q <= (in_func_i == FUNC_WRITE);
      id_q    <= in_id_i;
    end
    if (step_found) pend_q <= sel_res;
    if (do_acc) begin
      out_q <= acc_res;
    end else if (do_step && flush_end) begin
      out_q <= end_res;
    end else if (step_found && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (do_acc && !hit && !full) occ_d = occ_q + OW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      dirty_q      <= '0;
      occ_q        <= '0;
      walk_q       <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      occ_q <= occ_d;
      if (do_acc) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit) begin
            if (match[i]) begin
              rank_q[i] <= '0;
              if (write_q) dirty_q[i] <= 1'b1;
            end else if (valid_q[i] && rank_q[i] < old_rank) begin
              rank_q[i] <= rank_q[i] + IW'(1);
            end
          end else if (IW'(i) == new_idx) begin
            rank_q[i]  <= '0;
            valid_q[i] <= 1'b1;
            dirty_q[i] <= write_q;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + IW'(1);
          end
        end
      end
      if (ctrl_i.cmd == CMD_CAPTURE) begin
        walk_q       <= '0;
        cnt_q        <= '0;
        pend_valid_q <= 1'b0;
      end else if (do_step && !flush_end) begin
        walk_q <= walk_q + OW'(1);
        if (sel_dirty) begin
          cnt_q        <= cnt_q + CNT_BITS'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (do_acc || (do_step && flush_end) || (step_found && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy  = out_valid_q && !out_ready_i;
  assign stat_o.flush_end = flush_end;
  assign out_o            = out_q;
  assign out_valid_o      = out_valid_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FULL) else $error("occupancy beyond capacity");
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_acc |-> $onehot0(match)) else $error("tag held in two slots");
  a_occ_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_acc && !hit && !full) |=> (occ_q == $past(occ_q) + OW'(1)))
    else $error("miss did not take a free slot");
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q)) else $error("valid marks disagree with occupancy");

endmodule
`default_nettype wire
